FILE: hdl/mpe_pkg.sv
package mpe_pkg;

	// Coordinate format defaults (Q4.28)
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 28;

	// Multiplier slice width: one slice product per cycle
	localparam int CHUNK_W = 32;

	// Palette
	localparam int PALETTE_SIZE = 16;
	localparam int PAL_IDX_W    = $clog2(PALETTE_SIZE);

	// Field widths
	localparam int COL_W    = 12;
	localparam int ROW_W    = 12;
	localparam int CHAN_W   = 8;
	localparam int ITER_W   = 16;
	localparam int ORIGIN_W = 32;
	localparam int STEP_W   = 31;
	localparam int HEIGHT_W = 13;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_ORIGIN_RE = 3'd0;
	localparam cfg_idx_t CFG_ORIGIN_IM = 3'd1;
	localparam cfg_idx_t CFG_STEP_RE   = 3'd2;
	localparam cfg_idx_t CFG_STEP_IM   = 3'd3;
	localparam cfg_idx_t CFG_HEIGHT    = 3'd4;
	localparam cfg_idx_t CFG_MAX_ITER  = 3'd5;

	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_RE = -32'sd536870912;
	localparam logic signed [ORIGIN_W-1:0] RST_ORIGIN_IM = -32'sd268435456;
	localparam logic [STEP_W-1:0]          RST_STEP_RE   = 31'd786432;
	localparam logic [STEP_W-1:0]          RST_STEP_IM   = 31'd1048576;
	localparam logic [HEIGHT_W-1:0]        RST_HEIGHT    = 13'd512;
	localparam logic [ITER_W-1:0]          RST_MAX_ITER  = 16'd2000;

	typedef struct packed {
		logic [COL_W-1:0] column;
		logic [ROW_W-1:0] row;
	} pixel_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
		logic [ITER_W-1:0] iterations;
	} result_t;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} rgb_t;

	// Controller to datapath
	typedef struct packed {
		logic map_en;
		logic org_en;
		logic mul_en;
		logic rnd_en;
		logic upd_en;
		logic out_load;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic zero_limit;
		logic mul_last;
		logic escaped;
		logic limit_hit;
	} dp_sts_t;

	function automatic rgb_t palette(input logic [PAL_IDX_W-1:0] idx);
		rgb_t c;
		case (idx)
			4'd0:    c = '{8'd66,  8'd30,  8'd15};
			4'd1:    c = '{8'd25,  8'd7,   8'd26};
			4'd2:    c = '{8'd9,   8'd1,   8'd47};
			4'd3:    c = '{8'd4,   8'd4,   8'd73};
			4'd4:    c = '{8'd0,   8'd7,   8'd100};
			4'd5:    c = '{8'd12,  8'd44,  8'd138};
			4'd6:    c = '{8'd24,  8'd82,  8'd177};
			4'd7:    c = '{8'd57,  8'd125, 8'd209};
			4'd8:    c = '{8'd134, 8'd181, 8'd229};
			4'd9:    c = '{8'd211, 8'd236, 8'd248};
			4'd10:   c = '{8'd241, 8'd233, 8'd191};
			4'd11:   c = '{8'd248, 8'd201, 8'd95};
			4'd12:   c = '{8'd255, 8'd170, 8'd0};
			4'd13:   c = '{8'd204, 8'd128, 8'd0};
			4'd14:   c = '{8'd153, 8'd87,  8'd0};
			4'd15:   c = '{8'd106, 8'd52,  8'd3};
			default: c = '{8'd66,  8'd30,  8'd15};
		endcase
		return c;
	endfunction

endpackage

FILE: hdl/mpe_out.sv
module mpe_out import mpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  logic [ITER_W-1:0] iterations,
	output logic              result_valid,
	input  logic              result_ready,
	output result_t           result,
	output logic              free
);

	logic    valid_q;
	result_t res_q;
	rgb_t    rgb;

	assign rgb = palette(iterations[PAL_IDX_W-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= '{rgb.red, rgb.green, rgb.blue, iterations};
		end
	end

	assign free         = !valid_q || result_ready;
	assign result_valid = valid_q;
	assign result       = res_q;

endmodule

FILE: hdl/mpe_dp.sv
module mpe_dp import mpe_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  pixel_t                pixel,
	input  cmd_t                  cmd,
	output dp_sts_t               sts,
	output logic [ITER_W-1:0]     iterations
);

	localparam int CW    = COORD_WIDTH;
	localparam int K     = (CW + CHUNK_W - 1) / CHUNK_W;
	localparam int PW    = K * CHUNK_W;
	localparam int AW    = 2 * PW;
	localparam int CIW   = (K > 1) ? $clog2(K) : 1;
	localparam int MAP_W = 48;
	localparam int SW    = (CW > MAP_W) ? CW : MAP_W;
	localparam int ESC_W = (CW + 1 > FRAC_BITS + 3) ? CW + 1 : FRAC_BITS + 3;

	localparam logic signed [CW-1:0] CMAX   = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0] CMIN   = {1'b1, {(CW-1){1'b0}}};
	localparam logic signed [SW-1:0] CMAX_W = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
	localparam logic signed [SW-1:0] CMIN_W = ~CMAX_W;
	localparam logic [ESC_W-1:0]     FOUR   = ESC_W'(1) << (FRAC_BITS + 2);

	// Configuration registers
	logic signed [ORIGIN_W-1:0] origin_re_q, origin_im_q;
	logic [STEP_W-1:0]          step_re_q, step_im_q;
	logic [HEIGHT_W-1:0]        height_q;
	logic [ITER_W-1:0]          max_iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_re_q <= RST_ORIGIN_RE;
			origin_im_q <= RST_ORIGIN_IM;
			step_re_q   <= RST_STEP_RE;
			step_im_q   <= RST_STEP_IM;
			height_q    <= RST_HEIGHT;
			max_iter_q  <= RST_MAX_ITER;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_ORIGIN_RE: origin_re_q <= $signed(cfg_wdata[ORIGIN_W-1:0]);
				CFG_ORIGIN_IM: origin_im_q <= $signed(cfg_wdata[ORIGIN_W-1:0]);
				CFG_STEP_RE:   step_re_q   <= cfg_wdata[STEP_W-1:0];
				CFG_STEP_IM:   step_im_q   <= cfg_wdata[STEP_W-1:0];
				CFG_HEIGHT:    height_q    <= cfg_wdata[HEIGHT_W-1:0];
				CFG_MAX_ITER:  max_iter_q  <= cfg_wdata[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	// Pixel to point mapping
	logic [STEP_W+COL_W-1:0]  pre_re_q;
	logic signed [46:0]       pre_im_q;
	logic signed [14:0]       row_term;
	logic signed [SW-1:0]     sum_re, sum_im;

	assign row_term = $signed({2'b00, height_q}) - $signed({3'b000, pixel.row});

	always_ff @(posedge clk) begin
		if (cmd.map_en) begin
			pre_re_q <= step_re_q * pixel.column;
			pre_im_q <= $signed({1'b0, step_im_q}) * row_term;
		end
	end

	assign sum_re = SW'(origin_re_q) + SW'($signed({1'b0, pre_re_q}));
	assign sum_im = SW'(origin_im_q) + SW'(pre_im_q);

	function automatic logic signed [CW-1:0] clamp_map(input logic signed [SW-1:0] v);
		if (v > CMAX_W) return CMAX;
		if (v < CMIN_W) return CMIN;
		return v[CW-1:0];
	endfunction

	function automatic logic signed [CW-1:0] sat1(input logic [CW:0] v);
		if (v[CW] != v[CW-1]) return v[CW] ? CMIN : CMAX;
		return v[CW-1:0];
	endfunction

	function automatic logic [PW-1:0] mag(input logic signed [CW-1:0] v);
		logic [CW-1:0] u;
		u = v;
		if (u[CW-1]) u = ~u + 1'b1;
		return PW'(u);
	endfunction

	// Floor shift of the signed product, then clamp to the coordinate range
	function automatic logic signed [CW-1:0] rnd_sat(input logic [AW-1:0] m, input logic neg);
		logic signed [AW:0] p;
		logic signed [AW:0] s;
		p = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
		s = p >>> FRAC_BITS;
		if ((&s[AW:CW-1]) || !(|s[AW:CW-1])) return s[CW-1:0];
		return s[AW] ? CMIN : CMAX;
	endfunction

	// Iteration state
	logic signed [CW-1:0] cre_q, cim_q, zr_q, zi_q;
	logic [ITER_W-1:0]    n_q;
	logic signed [CW-1:0] zr2_q, zi2_q, xy_q;
	logic signed [CW-1:0] xy2, dzr, zr_next, zi_next;

	// Slice multipliers
	logic [CIW-1:0]     i_q, j_q;
	logic [PW-1:0]      mzr, mzi;
	logic [CHUNK_W-1:0] zr_ci, zr_cj, zi_cj;
	logic [2*CHUNK_W-1:0] pp_rr, pp_ii, pp_ri;
	logic [CIW:0]       slice_sum;
	logic [AW-1:0]      sh_rr, sh_ii, sh_ri;
	logic [AW-1:0]      acc_rr_q, acc_ii_q, acc_ri_q;
	logic               first, last;

	assign mzr   = mag(zr_q);
	assign mzi   = mag(zi_q);
	assign zr_ci = mzr[i_q*CHUNK_W +: CHUNK_W];
	assign zr_cj = mzr[j_q*CHUNK_W +: CHUNK_W];
	assign zi_cj = mzi[j_q*CHUNK_W +: CHUNK_W];
	logic [CHUNK_W-1:0] zi_ci;
	assign zi_ci = mzi[i_q*CHUNK_W +: CHUNK_W];

	assign pp_rr = zr_ci * zr_cj;
	assign pp_ii = zi_ci * zi_cj;
	assign pp_ri = zr_ci * zi_cj;

	assign slice_sum = {1'b0, i_q} + {1'b0, j_q};
	assign sh_rr     = AW'(pp_rr) << (slice_sum * CHUNK_W);
	assign sh_ii     = AW'(pp_ii) << (slice_sum * CHUNK_W);
	assign sh_ri     = AW'(pp_ri) << (slice_sum * CHUNK_W);

	assign first = (i_q == '0) && (j_q == '0);
	assign last  = (i_q == CIW'(K-1)) && (j_q == CIW'(K-1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
		end else if (cmd.mul_en) begin
			if (j_q == CIW'(K-1)) begin
				j_q <= '0;
				if (i_q == CIW'(K-1)) i_q <= '0;
				else i_q <= i_q + 1'b1;
			end else begin
				j_q <= j_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			acc_rr_q <= first ? sh_rr : acc_rr_q + sh_rr;
			acc_ii_q <= first ? sh_ii : acc_ii_q + sh_ii;
			acc_ri_q <= first ? sh_ri : acc_ri_q + sh_ri;
		end
		if (cmd.rnd_en) begin
			zr2_q <= rnd_sat(acc_rr_q, 1'b0);
			zi2_q <= rnd_sat(acc_ii_q, 1'b0);
			xy_q  <= rnd_sat(acc_ri_q, zr_q[CW-1] ^ zi_q[CW-1]);
		end
		if (cmd.org_en) begin
			cre_q <= clamp_map(sum_re);
			cim_q <= clamp_map(sum_im);
			zr_q  <= '0;
			zi_q  <= '0;
			n_q   <= '0;
		end else if (cmd.upd_en) begin
			zr_q <= zr_next;
			zi_q <= zi_next;
			n_q  <= n_q + 1'b1;
		end
	end

	// Update: each sum clamps on its own, in the order of the recurrence
	assign xy2     = sat1({xy_q, 1'b0});
	assign zi_next = sat1({xy2[CW-1], xy2} + {cim_q[CW-1], cim_q});
	assign dzr     = sat1({zr2_q[CW-1], zr2_q} - {zi2_q[CW-1], zi2_q});
	assign zr_next = sat1({dzr[CW-1], dzr} + {cre_q[CW-1], cre_q});

	logic [ESC_W-1:0] esc_sum;
	assign esc_sum = ESC_W'($unsigned(zr2_q)) + ESC_W'($unsigned(zi2_q));

	assign sts.zero_limit = (max_iter_q == '0);
	assign sts.mul_last   = last;
	assign sts.escaped    = (esc_sum >= FOUR);
	assign sts.limit_hit  = (({1'b0, n_q} + 1'b1) == {1'b0, max_iter_q});
	assign iterations     = n_q;

	a_upd_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.upd_en |-> (n_q < max_iter_q))
		else $error("update past the iteration limit");

	a_org_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.org_en |=> (n_q == '0 && zr_q == '0 && zi_q == '0))
		else $error("iteration state not cleared at start of pixel");

	a_slice_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_en && last) |=> first)
		else $error("slice counters did not wrap after last slice");

endmodule

FILE: hdl/mpe_ctrl.sv
module mpe_ctrl import mpe_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    pixel_valid,
	output logic    pixel_ready,
	input  dp_sts_t dp_sts,
	input  logic    out_free,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_ORG  = 6'b000010,
		S_MUL  = 6'b000100,
		S_RND  = 6'b001000,
		S_ADD  = 6'b010000,
		S_DONE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd         = '0;
		pixel_ready = 1'b0;
		state_d     = state_q;
		case (state_q)
			S_IDLE: begin
				pixel_ready = 1'b1;
				if (pixel_valid) begin
					cmd.map_en = 1'b1;
					state_d    = S_ORG;
				end
			end
			S_ORG: begin
				cmd.org_en = 1'b1;
				state_d    = dp_sts.zero_limit ? S_DONE : S_MUL;
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				if (dp_sts.mul_last) state_d = S_RND;
			end
			S_RND: begin
				cmd.rnd_en = 1'b1;
				state_d    = S_ADD;
			end
			S_ADD: begin
				if (dp_sts.escaped) begin
					state_d = S_DONE;
				end else begin
					cmd.upd_en = 1'b1;
					state_d    = dp_sts.limit_hit ? S_DONE : S_MUL;
				end
			end
			S_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pixel_valid && pixel_ready) |=> (state_q == S_ORG))
		else $error("accepted item did not start mapping");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> out_free)
		else $error("result loaded over an untaken result");

	a_escape_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ADD && dp_sts.escaped) |=> (state_q == S_DONE && !cmd.upd_en))
		else $error("escaped point kept iterating");

endmodule

FILE: hdl/mandelbrot_pixel_engine_core.sv
// Escape-time pixel engine: one pixel in, one coloured result out.
// Pixel channel (pixel_valid/pixel_ready/pixel): column and row of a pixel. The point
// c = origin + step*(column, frame_height - row) is iterated as z = z*z + c from zero
// until |z|^2 reaches 4 or max_iter updates are done.
// Result channel (result_valid/result_ready/result): palette colour picked by the count
// mod 16, and the count itself.
// Configuration: cfg_we, cfg_index, cfg_wdata write one register per cycle; write only
// while no item is in flight.
// Iteration: slice products over K slices per operand, K = COORD_WIDTH/32 rounded up,
// then round and clamp, then add and escape test.
// Throughput: one item at a time; pixel_ready is high only when the engine is idle.
// The result register parts the two sides: a new item may be taken while the previous
// result waits, and the engine stalls only if it finishes while that result is still
// untaken.
// Reset: clears the controller and the result valid, and loads the register defaults.
module mandelbrot_pixel_engine_core import mpe_pkg::*; #(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  pixel_t                pixel,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  cfg_we,
	input  cfg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cmd_t              cmd;
	dp_sts_t           dp_sts;
	logic              out_free;
	logic [ITER_W-1:0] iterations;

	// Sequence mapping, slice multiplies, rounding and update for each item
	mpe_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_ready (pixel_ready),
		.dp_sts      (dp_sts),
		.out_free    (out_free),
		.cmd         (cmd)
	);

	// Hold the registers, the point and the running iterate
	mpe_dp #(
		.COORD_WIDTH (COORD_WIDTH),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pixel      (pixel),
		.cmd        (cmd),
		.sts        (dp_sts),
		.iterations (iterations)
	);

	// Colour the count and hold the item until the receiver takes it
	mpe_out u_out (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (cmd.out_load),
		.iterations   (iterations),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.free         (out_free)
	);

endmodule
